>>> design/bounded_deque_with_search_unit_macros.svh
// Assertion macros for the bounded deque. Each macro checks on the rising
// edge of aclk and is disabled while aresetn is low.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_UNIT_MACROS_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_UNIT_MACROS_SVH

`ifndef SYNTH

// The expression holds at every clock edge.
`define BDQ_ASSERT_ALWAYS(lbl, expr) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("deque invariant violated");

// When the antecedent holds, the consequent holds in the same cycle.
`define BDQ_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("deque implication violated");

// When the antecedent holds, the consequent holds in the next cycle.
`define BDQ_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("deque next-cycle check violated");

`else

`define BDQ_ASSERT_ALWAYS(lbl, expr)
`define BDQ_ASSERT_IMPLIES(lbl, ante, cons)
`define BDQ_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

>>> design/bdq_pkg.sv
package bdq_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int SUM_W    = IDX_W + 1;
    localparam int CNT_W    = 5;
    localparam int DATA_W   = 32;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [DATA_W-1:0] data_t;

    typedef enum logic [2:0] {
        MODE_PUSH_FRONT = 3'd0,
        MODE_PUSH_BACK  = 3'd1,
        MODE_POP_FRONT  = 3'd2,
        MODE_POP_BACK   = 3'd3,
        MODE_SEARCH     = 3'd4
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SRCH
    } state_t;

    // Physical slot of the entry that lies offset places behind the head.
    // Both operands are below CAPACITY, so one conditional subtract wraps it.
    function automatic idx_t slot_at(idx_t head, idx_t offset);
        logic [SUM_W-1:0] sum;
        sum = {1'b0, head} + {1'b0, offset};
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    // Slot in front of the head, wrapping below zero.
    function automatic idx_t slot_before(idx_t head);
        idx_t prev;
        if (head == '0) begin
            prev = IDX_W'(CAPACITY - 1);
        end else begin
            prev = head - idx_t'(1);
        end
        return prev;
    endfunction

endpackage

>>> design/bounded_deque_with_search_unit.sv
// Bounded double-ended queue of signed 32-bit values with a membership search.
// Each item on the s_ channel is one request (push front, push back, pop front,
// pop back or search) and produces exactly one item on the m_ channel carrying
// the popped value, the found flag, the entry count after the request and a
// status (ok, empty on a pop, full on a push). Entries live in a 16-entry
// synchronous memory with registered read data, addressed as a circular
// buffer from a head pointer. The block works on one request at a time: a push
// is answered at once, a pop reads the memory and answers from the registered
// read data, and a search reads the stored entries in order from the head,
// with an early exit on the first match. The search rate is set by the
// single memory read port, which delivers one entry per cycle. A new request is
// taken whenever the unit is idle and the result register is empty or is being
// drained in the same cycle. Codes five to seven are answered as no-ops.
`include "bounded_deque_with_search_unit_macros.svh"

module bounded_deque_with_search_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_mode,
    input  logic signed [31:0]   s_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_popped_value,
    output logic                 m_found,
    output logic [4:0]           m_entry_count,
    output logic [1:0]           m_status
);
    import bdq_pkg::*;

    // Entry memory: written at one address and read at one address per cycle,
    // with the read data registered.
    data_t   mem [CAPACITY];
    data_t   rd_data_reg;

    logic    wr_en;
    idx_t    wr_addr;
    data_t   wr_data;
    logic    rd_en;
    idx_t    rd_addr;

    // Control state.
    state_t  state_reg,  state_next;
    idx_t    head_reg,   head_next;
    cnt_t    count_reg,  count_next;
    idx_t    srch_idx_reg, srch_idx_next;
    data_t   key_reg,    key_next;

    // Result register.
    logic    m_valid_reg, m_valid_next;
    data_t   popped_reg,  popped_next;
    logic    found_reg,   found_next;
    cnt_t    ecount_reg,  ecount_next;
    status_t status_reg,  status_next;

    logic    accept;
    logic    out_free;
    logic    is_full;
    logic    is_empty;
    idx_t    last_off;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;
    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    // Offset of the back entry; only used when the queue is not empty.
    assign last_off = IDX_W'(count_reg - cnt_t'(1));

    assign m_valid        = m_valid_reg;
    assign m_popped_value = popped_reg;
    assign m_found        = found_reg;
    assign m_entry_count  = ecount_reg;
    assign m_status       = status_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        srch_idx_reg <= srch_idx_next;
        key_reg      <= key_next;
        popped_reg   <= popped_next;
        found_reg    <= found_next;
        ecount_reg   <= ecount_next;
        status_reg   <= status_next;
    end

    always_comb begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        srch_idx_next = srch_idx_reg;
        key_next      = key_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        popped_next   = popped_reg;
        found_next    = found_reg;
        ecount_next   = ecount_reg;
        status_next   = status_reg;
        wr_en         = 1'b0;
        wr_addr       = head_reg;
        wr_data       = s_value;
        rd_en         = 1'b0;
        rd_addr       = head_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    // Defaults for an immediate result; pops and searches on a non-empty
                    // queue override the valid bit and finish later.
                    m_valid_next = 1'b1;
                    popped_next  = '0;
                    found_next   = 1'b0;
                    status_next  = ST_OK;
                    ecount_next  = count_reg;
                    unique case (s_mode)
                        MODE_PUSH_FRONT: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                head_next   = slot_before(head_reg);
                                wr_en       = 1'b1;
                                wr_addr     = slot_before(head_reg);
                                count_next  = count_reg + cnt_t'(1);
                                ecount_next = count_reg + cnt_t'(1);
                            end
                        end
                        MODE_PUSH_BACK: begin
                            if (is_full) begin
                                status_next = ST_FULL;
                            end else begin
                                wr_en       = 1'b1;
                                wr_addr     = slot_at(head_reg, IDX_W'(count_reg));
                                count_next  = count_reg + cnt_t'(1);
                                ecount_next = count_reg + cnt_t'(1);
                            end
                        end
                        MODE_POP_FRONT: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                rd_en        = 1'b1;
                                rd_addr      = head_reg;
                                head_next    = slot_at(head_reg, idx_t'(1));
                                count_next   = count_reg - cnt_t'(1);
                                m_valid_next = 1'b0;
                                state_next   = S_POP;
                            end
                        end
                        MODE_POP_BACK: begin
                            if (is_empty) begin
                                status_next = ST_EMPTY;
                            end else begin
                                rd_en        = 1'b1;
                                rd_addr      = slot_at(head_reg, last_off);
                                count_next   = count_reg - cnt_t'(1);
                                m_valid_next = 1'b0;
                                state_next   = S_POP;
                            end
                        end
                        MODE_SEARCH: begin
                            if (!is_empty) begin
                                rd_en         = 1'b1;
                                rd_addr       = head_reg;
                                srch_idx_next = '0;
                                key_next      = s_value;
                                m_valid_next  = 1'b0;
                                state_next    = S_SRCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_POP: begin
                // Read data of the popped slot is now registered.
                m_valid_next = 1'b1;
                popped_next  = rd_data_reg;
                found_next   = 1'b0;
                ecount_next  = count_reg;
                status_next  = ST_OK;
                state_next   = S_IDLE;
            end
            S_SRCH: begin
                // rd_data_reg holds the entry at offset srch_idx_reg.
                if (rd_data_reg == key_reg) begin
                    m_valid_next = 1'b1;
                    popped_next  = '0;
                    found_next   = 1'b1;
                    ecount_next  = count_reg;
                    status_next  = ST_OK;
                    state_next   = S_IDLE;
                end else if (srch_idx_reg == last_off) begin
                    m_valid_next = 1'b1;
                    popped_next  = '0;
                    found_next   = 1'b0;
                    ecount_next  = count_reg;
                    status_next  = ST_OK;
                    state_next   = S_IDLE;
                end else begin
                    rd_en         = 1'b1;
                    rd_addr       = slot_at(head_reg, srch_idx_reg + idx_t'(1));
                    srch_idx_next = srch_idx_reg + idx_t'(1);
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `BDQ_ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY))
    `BDQ_ASSERT_IMPLIES(a_busy_out_empty, state_reg != S_IDLE, !m_valid_reg)
    `BDQ_ASSERT_IMPLIES(a_srch_in_window, state_reg == S_SRCH, srch_idx_reg <= last_off)
    `BDQ_ASSERT_NEXT(a_pop_empty,
        accept && is_empty && (s_mode == MODE_POP_FRONT || s_mode == MODE_POP_BACK),
        m_valid_reg && status_reg == ST_EMPTY)
    `BDQ_ASSERT_NEXT(a_push_full,
        accept && is_full && (s_mode == MODE_PUSH_FRONT || s_mode == MODE_PUSH_BACK),
        m_valid_reg && status_reg == ST_FULL && count_reg == CNT_W'(CAPACITY))

endmodule
